// ----- rtl/core/pcsh_pkg.sv -----
// ----------------------------------------------------------------------------
// pcsh_pkg
// Shared constants, types and the bit-length helper for the bf16 x half multiply.
// ----------------------------------------------------------------------------
package pcsh_pkg;

    localparam int unsigned MaxChannels = 4096;
    localparam int unsigned ColW        = 12;
    localparam int unsigned LenW        = 13;
    localparam int unsigned HalfW       = 16;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_SCALE = 1'b1
    } t_opcode;

    // first multiply stage result: sign, special case, significand product, exponent
    typedef struct packed {
        logic [15:0]     sign;
        logic            special;
        logic [15:0]     special_val;
        logic [18:0]     sig_prod;
        logic signed [9:0] exp_sum;
    } t_mul_s1;

    typedef struct packed {
        logic [ColW-1:0] channel;
        logic            row_end;
        logic            final_out;
    } t_side;

    // bit length of a 19-bit value
    function automatic logic [4:0] bit_len19(input logic [18:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 19; i++) begin
            if (v[i]) n = 5'(i + 1);
        end
        return n;
    endfunction

endpackage

// ----- rtl/core/pcsh_mul.sv -----
// ----------------------------------------------------------------------------
// pcsh_mul
// Two-stage bf16 x half multiply with one round-to-nearest-even to half.
// ----------------------------------------------------------------------------
module pcsh_mul (
    input  logic        i_clk,
    input  logic        i_en1,
    input  logic        i_en2,
    input  logic [15:0] i_act,
    input  logic [15:0] i_scale,
    output logic [15:0] o_prod
);
    import pcsh_pkg::*;

    logic [7:0]  ae;
    logic [6:0]  am;
    logic [4:0]  be;
    logic [9:0]  bm;
    logic        anan, ainf, bnan, binf, azero, bzero;
    logic [7:0]  sa;
    logic [10:0] sb;
    logic signed [9:0] ea, eb;
    t_mul_s1     n_s1, r_s1;

    always_comb begin
        ae = i_act[14:7];
        am = i_act[6:0];
        be = i_scale[14:10];
        bm = i_scale[9:0];
        anan  = (ae == 8'hFF) && (am != '0);
        ainf  = (ae == 8'hFF) && (am == '0);
        bnan  = (be == 5'h1F) && (bm != '0);
        binf  = (be == 5'h1F) && (bm == '0);
        azero = (ae == '0) && (am == '0);
        bzero = (be == '0) && (bm == '0);
        sa = (ae == '0) ? {1'b0, am} : {1'b1, am};
        sb = (be == '0) ? {1'b0, bm} : {1'b1, bm};
        ea = (ae == '0) ? -10'sd126 : $signed({2'b00, ae}) - 10'sd127;
        eb = (be == '0) ? -10'sd14 : $signed({5'b0, be}) - 10'sd15;
        n_s1.sign     = {i_act[15] ^ i_scale[15], 15'b0};
        n_s1.special  = 1'b1;
        n_s1.sig_prod = 19'(sa) * 19'(sb);
        n_s1.exp_sum  = ea + eb - 10'sd17;
        if (anan || bnan || (ainf && bzero) || (binf && azero)) begin
            n_s1.special_val = 16'h7E00;
        end else if (ainf || binf) begin
            n_s1.special_val = n_s1.sign | 16'h7C00;
        end else if (azero || bzero) begin
            n_s1.special_val = n_s1.sign;
        end else begin
            n_s1.special     = 1'b0;
            n_s1.special_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) r_s1 <= n_s1;
    end

    // normalize and round
    logic [4:0]        n_len;
    logic signed [9:0] ex, qexp, diff;
    logic [5:0]        sh;
    logic [31:0]       pw, rem, halfw, q;
    logic [16:0]       bits;
    logic [15:0]       n_prod, r_prod;

    always_comb begin
        n_len = bit_len19(r_s1.sig_prod);
        ex    = r_s1.exp_sum + $signed({5'b0, n_len}) - 10'sd1;
        qexp  = ((ex < -10'sd14) ? -10'sd14 : ex) - 10'sd10;
        diff  = qexp - r_s1.exp_sum;
        pw    = {13'b0, r_s1.sig_prod};
        sh    = '0;
        rem   = '0;
        halfw = '0;
        if (diff <= 0) begin
            q = pw << 6'(-diff);
        end else if (diff > 10'sd24) begin
            q = '0;
        end else begin
            sh    = 6'(diff);
            rem   = pw & ((32'd1 << sh) - 32'd1);
            halfw = 32'd1 << (sh - 6'd1);
            q     = pw >> sh;
            if (rem > halfw || (rem == halfw && q[0])) q = q + 32'd1;
        end
        bits = 17'({qexp + 10'sd24, 10'b0}) + 17'(q);
        if (q == '0) bits = '0;
        if (r_s1.special) begin
            n_prod = r_s1.special_val;
        end else if (ex > 10'sd15 || bits >= 17'h7C00) begin
            n_prod = r_s1.sign | 16'h7C00;
        end else begin
            n_prod = r_s1.sign | bits[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/per_channel_scale_to_half.sv -----
// ----------------------------------------------------------------------------
// per_channel_scale_to_half
// Scales a bf16 activation stream by per-channel half factors held in a RAM.
// ----------------------------------------------------------------------------
// Path: an accepted scale transfer passes the RAM read, multiply and
//   normalize/round registers before its result reaches the master side.
// Throughput: one transfer per cycle; the 3-stage pipeline advances only when
//   its output stage is free or being taken, so the skid is the pipe itself.
// Reset: synchronous active low; clears the column counter, the pipeline valid
//   bits and sets row_length to 4096. The scale RAM is not cleared.
module per_channel_scale_to_half #(
    parameter int unsigned MAX_CHANNELS = pcsh_pkg::MaxChannels
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: [11:0] entry_index, [27:12] scale_half, [43:28] activation_bf16
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // final_element
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: [15:0] product_half, [27:16] channel, [28] row_end
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast    // final_out
);
    import pcsh_pkg::*;

    localparam int unsigned AW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned Cap = (MAX_CHANNELS < 4096) ? MAX_CHANNELS : 4096;

    logic [LenW-1:0] r_row_length;
    logic [ColW-1:0] r_col;
    logic [HalfW-1:0] r_mem [MAX_CHANNELS];
    logic [HalfW-1:0] r_rd;
    logic            r_rd_ok;       // counter was inside the table
    logic [15:0]     r_act;

    logic r_v1, r_v2, r_v3;
    t_side r_sd1, r_sd2, r_sd3;
    logic adv, acc, is_wr, is_sc;
    logic [ColW-1:0]  idx;
    logic [LenW-1:0]  len;
    logic             n_end;
    logic [15:0]      prod;

    // Advance the whole pipe when the output slot frees or is empty.
    assign adv = !r_v3 || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc = s_axis_tvalid && adv;
    assign is_wr = acc && (t_opcode'(s_axis_tuser) == OP_WRITE);
    assign is_sc = acc && (t_opcode'(s_axis_tuser) == OP_SCALE);
    assign idx = s_axis_tdata[11:0];

    // Saturate row length into [1, Cap].
    always_comb begin
        len = r_row_length;
        if (len < 13'd1) len = 13'd1;
        if (len > LenW'(Cap)) len = LenW'(Cap);
        n_end = ({1'b0, r_col} + 13'd1) >= len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= 13'd4096;
            r_col        <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (i_cfg_we) r_row_length <= i_cfg_wdata;
            if (is_sc) r_col <= (s_axis_tlast || n_end) ? '0 : r_col + 1'b1;
            if (adv) begin
                r_v1 <= is_sc;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    // Scale RAM: one write port, one read port. Only one transfer is taken per
    // cycle, but the read runs in every advancing cycle, so a write shares its cycle
    // with a read of the old contents; a read in the cycle after a write sees the new data.
    always_ff @(posedge i_clk) begin
        if (is_wr && ({20'b0, idx} < 32'(MAX_CHANNELS))) r_mem[AW'(idx)] <= s_axis_tdata[27:12];
        if (adv) begin
            r_rd    <= r_mem[AW'(r_col)];
            r_rd_ok <= {20'b0, r_col} < 32'(MAX_CHANNELS);
            r_act   <= s_axis_tdata[43:28];
            r_sd1   <= '{channel: r_col, row_end: n_end, final_out: s_axis_tlast};
            r_sd2   <= r_sd1;
            r_sd3   <= r_sd2;
        end
    end

    pcsh_mul u_mul (
        .i_clk  (i_clk),
        .i_en1  (adv),
        .i_en2  (adv),
        .i_act  (r_act),
        .i_scale(r_rd_ok ? r_rd : 16'h0000),
        .o_prod (prod)
    );

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {3'b0, r_sd3.row_end, r_sd3.channel, prod};
    assign m_axis_tlast  = r_sd3.final_out;

    // A held result must not change while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed during stall");
    // The counter returns to zero after a final scale transfer.
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_sc && s_axis_tlast) |=> (r_col == '0))
        else $error("counter not cleared by final");
    // Inside the row the counter steps by one.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_sc && !s_axis_tlast && !n_end) |=> (r_col == $past(r_col) + 1'b1))
        else $error("counter step wrong");

endmodule
